// File: hw/rtl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// shared types and constants of the radar measurement jacobian datapath
// ----------------------------------------------------------------------------
package rmj_pkg;

  // reset value of the squared range threshold
  localparam logic [16:0] MIN_RANGE_SQ_RESET = 17'd7;

  // quotient bits resolved by each divider (32-bit result plus overflow bit)
  localparam int QBITS = 33;

  // per-item side data carried from the product stages to the dividers
  typedef struct packed {
    logic [31:0] apx;
    logic [31:0] apy;
    logic        nx;
    logic        ny;
    logic        pyp;
    logic        cneg;
    logic        near;
    logic [63:0] r2;
    logic [95:0] npx;
    logic [95:0] npy;
  } side_t;

endpackage

// File: hw/rtl/rmj_sqrt.sv
// ----------------------------------------------------------------------------
// rmj_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rmj_sqrt
  import rmj_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int STEPS = 32;

  logic [33:0] rem_q  [STEPS];
  logic [31:0] root_q [STEPS];
  logic [63:0] rad_q  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [35:0] trial_rem;
    logic [35:0] trial;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign trial_rem = {rem_in, rad_in[63:62]};
    assign trial     = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial_rem >= trial) begin
          rem_q[s]  <= 34'(trial_rem - trial);
          root_q[s] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[s]  <= trial_rem[33:0];
          root_q[s] <= {root_in[30:0], 1'b0};
        end
        rad_q[s] <= {rad_in[61:0], 2'b00};
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule

// File: hw/rtl/rmj_div.sv
// ----------------------------------------------------------------------------
// rmj_div
// pipelined restoring divider with signed saturation to 32 bits
// ----------------------------------------------------------------------------
module rmj_div
  import rmj_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg,
  input  logic          zero,
  output logic [31:0]   q
);

  localparam int HW = NW - QBITS;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  logic [DW-1:0]    rem_q  [QBITS+1];
  logic [QBITS-1:0] low_q  [QBITS+1];
  logic [DW-1:0]    den_q  [QBITS+1];
  logic             neg_q  [QBITS+1];
  logic             zero_q [QBITS+1];
  logic             ovf_q  [QBITS+1];

  assign hi_ext  = CW'(num[NW-1:QBITS]);
  assign den_ext = CW'(den);

  // overflow check: quotient needs more than the resolved bits
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0]  <= (hi_ext >= den_ext);
      rem_q[0]  <= hi_ext[DW-1:0];
      low_q[0]  <= num[QBITS-1:0];
      den_q[0]  <= den;
      neg_q[0]  <= neg;
      zero_q[0] <= zero;
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_step
    logic [DW:0] part;
    assign part = {rem_q[s-1], low_q[s-1][QBITS-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= {1'b0, den_q[s-1]}) begin
          rem_q[s] <= DW'(part - {1'b0, den_q[s-1]});
          low_q[s] <= {low_q[s-1][QBITS-2:0], 1'b1};
        end else begin
          rem_q[s] <= part[DW-1:0];
          low_q[s] <= {low_q[s-1][QBITS-2:0], 1'b0};
        end
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
    end
  end

  logic [QBITS-1:0] cap;
  logic [QBITS-1:0] mag;
  logic [QBITS-1:0] mag_neg;

  always_comb begin
    cap     = neg_q[QBITS] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    mag     = (ovf_q[QBITS] || (low_q[QBITS] > cap)) ? cap : low_q[QBITS];
    mag_neg = 33'(33'd0 - mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_q[QBITS]) begin
        q <= '0;
      end else if (neg_q[QBITS]) begin
        q <= mag_neg[31:0];
      end else begin
        q <= mag[31:0];
      end
    end
  end

endmodule

// File: hw/rtl/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// nonzero entries of the radar range / bearing / range-rate jacobian
// ----------------------------------------------------------------------------
// The block takes one track state (pos_x, pos_y, vel_x, vel_y, signed fixed
// point with FRAC_BITS fraction bits) per cycle while in_stall is low and
// returns the eight nonzero jacobian entries in the same format, saturated
// to 32 bits. Every transfer in gives exactly one transfer out, in order.
// The latency is set by the 32-stage square root for r and the 35-stage
// dividers (one quotient bit per divide step); the whole pipeline moves as
// one, so a held output holds every stage and in_stall follows out_valid and
// out_stall directly. When r squared is zero or below min_range_sq (written
// on cfg_wr_en, reset 7) all entries are zero and near_origin is set.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian
  import rmj_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] range_dpx,
  output logic signed [31:0] range_dpy,
  output logic signed [31:0] bearing_dpx,
  output logic signed [31:0] bearing_dpy,
  output logic signed [31:0] rate_dpx,
  output logic signed [31:0] rate_dpy,
  output logic signed [31:0] rate_dvx,
  output logic signed [31:0] rate_dvy,
  output logic               near_origin
);

  localparam int NSTAGE = 73;  // stage of the output registers
  localparam int DLY    = 33;  // side data from stage 5 to stage 38
  localparam int NDLY   = 35;  // near flag from stage 38 to the output

  // squared range threshold
  logic [16:0] min_range_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_sq <= MIN_RANGE_SQ_RESET;
    end else if (cfg_wr_en) begin
      min_range_sq <= cfg_wr_data;
    end
  end

  // whole pipeline advances unless a finished result is held
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // valid bits, one per stage
  logic vld [1:NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NSTAGE; i++) vld[i] <= 1'b0;
    end else if (advance) begin
      vld[1] <= in_valid;
      for (int i = 2; i <= NSTAGE; i++) vld[i] <= vld[i-1];
    end
  end

  assign out_valid = vld[NSTAGE];

  // stage 1: magnitudes and signs
  logic [31:0]        apx1, apy1;
  logic               nx1, ny1, pyp1;
  logic signed [31:0] px1, py1, vx1, vy1;

  always_ff @(posedge clk) begin
    if (advance) begin
      apx1 <= pos_x[31] ? 32'(-pos_x) : pos_x;
      apy1 <= pos_y[31] ? 32'(-pos_y) : pos_y;
      nx1  <= pos_x[31];
      ny1  <= pos_y[31];
      pyp1 <= !pos_y[31] && (pos_y != '0);
      px1  <= pos_x;
      py1  <= pos_y;
      vx1  <= vel_x;
      vy1  <= vel_y;
    end
  end

  // stage 2: squares and cross products
  logic [63:0]        sqx2, sqy2;
  logic signed [63:0] a2, b2;
  logic [31:0]        apx2, apy2;
  logic               nx2, ny2, pyp2;

  always_ff @(posedge clk) begin
    if (advance) begin
      sqx2 <= apx1 * apx1;
      sqy2 <= apy1 * apy1;
      a2   <= vx1 * py1;
      b2   <= vy1 * px1;
      apx2 <= apx1;
      apy2 <= apy1;
      nx2  <= nx1;
      ny2  <= ny1;
      pyp2 <= pyp1;
    end
  end

  // stage 3: r squared and the cross term as sign and magnitude
  logic [63:0] r2_3, cmag3;
  logic        cneg3;
  logic [31:0] apx3, apy3;
  logic        nx3, ny3, pyp3;

  always_ff @(posedge clk) begin
    if (advance) begin
      r2_3  <= sqx2 + sqy2;
      cneg3 <= (a2 < b2);
      cmag3 <= (a2 < b2) ? 64'(b2 - a2) : 64'(a2 - b2);
      apx3  <= apx2;
      apy3  <= apy2;
      nx3   <= nx2;
      ny3   <= ny2;
      pyp3  <= pyp2;
    end
  end

  // stage 4: threshold compare and rate numerator partial products
  logic [63:0] thr_ext;
  assign thr_ext = 64'(min_range_sq) << FRAC_BITS;

  logic [63:0] pxl4, pxh4, pyl4, pyh4;
  logic [63:0] r2_4;
  logic        near4, cneg4;
  logic [31:0] apx4, apy4;
  logic        nx4, ny4, pyp4;

  always_ff @(posedge clk) begin
    if (advance) begin
      near4 <= (r2_3 == '0) || (r2_3 < thr_ext);
      pxl4  <= apx3 * cmag3[31:0];
      pxh4  <= apx3 * cmag3[63:32];
      pyl4  <= apy3 * cmag3[31:0];
      pyh4  <= apy3 * cmag3[63:32];
      r2_4  <= r2_3;
      cneg4 <= cneg3;
      apx4  <= apx3;
      apy4  <= apy3;
      nx4   <= nx3;
      ny4   <= ny3;
      pyp4  <= pyp3;
    end
  end

  // stage 5: side data bundle with the full rate numerators
  side_t side5;

  always_ff @(posedge clk) begin
    if (advance) begin
      side5.apx  <= apx4;
      side5.apy  <= apy4;
      side5.nx   <= nx4;
      side5.ny   <= ny4;
      side5.pyp  <= pyp4;
      side5.cneg <= cneg4;
      side5.near <= near4;
      side5.r2   <= r2_4;
      side5.npx  <= (96'(pxh4) << 32) + 96'(pxl4);
      side5.npy  <= (96'(pyh4) << 32) + 96'(pyl4);
    end
  end

  // side data waits for r and r cubed
  side_t side_d [DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      side_d[0] <= side5;
      for (int i = 1; i < DLY; i++) side_d[i] <= side_d[i-1];
    end
  end

  // r = floor(sqrt(r2)), ready at stage 35
  logic [31:0] root;

  rmj_sqrt u_sqrt (
    .clk  (clk),
    .en   (advance),
    .rad  (r2_3),
    .root (root)
  );

  // stages 36 to 38: r cubed, 64 by 32 product split in two halves
  logic [63:0] rr36, pl37, ph37;
  logic [31:0] r36, r37, r38;
  logic [95:0] r3_38;

  always_ff @(posedge clk) begin
    if (advance) begin
      rr36  <= root * root;
      r36   <= root;
      pl37  <= rr36[31:0] * r36;
      ph37  <= rr36[63:32] * r36;
      r37   <= r36;
      r3_38 <= (96'(ph37) << 32) + 96'(pl37);
      r38   <= r37;
    end
  end

  side_t s38;
  assign s38 = side_d[DLY-1];

  logic [31:0] q_rx, q_ry, q_bx, q_by, q_tx, q_ty;

  // px / r and py / r
  rmj_div #(.NW(32 + FRAC_BITS), .DW(32)) u_div_rx (
    .clk (clk), .en (advance),
    .num ({s38.apx, {FRAC_BITS{1'b0}}}), .den (r38),
    .neg (s38.nx), .zero (s38.near), .q (q_rx)
  );

  rmj_div #(.NW(32 + FRAC_BITS), .DW(32)) u_div_ry (
    .clk (clk), .en (advance),
    .num ({s38.apy, {FRAC_BITS{1'b0}}}), .den (r38),
    .neg (s38.ny), .zero (s38.near), .q (q_ry)
  );

  // -py / r2 and px / r2
  rmj_div #(.NW(32 + 2 * FRAC_BITS), .DW(64)) u_div_bx (
    .clk (clk), .en (advance),
    .num ({s38.apy, {(2 * FRAC_BITS){1'b0}}}), .den (s38.r2),
    .neg (s38.pyp), .zero (s38.near), .q (q_bx)
  );

  rmj_div #(.NW(32 + 2 * FRAC_BITS), .DW(64)) u_div_by (
    .clk (clk), .en (advance),
    .num ({s38.apx, {(2 * FRAC_BITS){1'b0}}}), .den (s38.r2),
    .neg (s38.nx), .zero (s38.near), .q (q_by)
  );

  // range rate entries over r cubed
  rmj_div #(.NW(96 + FRAC_BITS), .DW(96)) u_div_tx (
    .clk (clk), .en (advance),
    .num ({s38.npy, {FRAC_BITS{1'b0}}}), .den (r3_38),
    .neg (s38.ny != s38.cneg), .zero (s38.near), .q (q_tx)
  );

  rmj_div #(.NW(96 + FRAC_BITS), .DW(96)) u_div_ty (
    .clk (clk), .en (advance),
    .num ({s38.npx, {FRAC_BITS{1'b0}}}), .den (r3_38),
    .neg (s38.nx == s38.cneg), .zero (s38.near), .q (q_ty)
  );

  // near flag rides alongside the dividers
  logic near_d [NDLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      near_d[0] <= s38.near;
      for (int i = 1; i < NDLY; i++) near_d[i] <= near_d[i-1];
    end
  end

  assign range_dpx   = q_rx;
  assign range_dpy   = q_ry;
  assign bearing_dpx = q_bx;
  assign bearing_dpy = q_by;
  assign rate_dpx    = q_tx;
  assign rate_dpy    = q_ty;
  assign rate_dvx    = q_rx;
  assign rate_dvy    = q_ry;
  assign near_origin = near_d[NDLY-1];

`ifndef SYNTHESIS
  a_near_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && near_origin |-> range_dpx == '0 && range_dpy == '0 &&
      bearing_dpx == '0 && bearing_dpy == '0 && rate_dpx == '0 && rate_dpy == '0)
    else $error("near origin result with nonzero entries");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    vld[1] && in_stall |=> vld[1])
    else $error("first stage lost an item while held");
`endif

endmodule
